>>> sv/swlat_pkg.sv
// Shared types and constants for the sliding window latency statistics block.
package swlat_pkg;

  localparam int TS_W    = 64;
  localparam int LAT_W   = 32;
  localparam int RATE_W  = 32;
  localparam int MEAN_W  = 40;
  localparam int FIW_W   = 7;
  localparam int Q_FRAC  = 8;
  localparam int SCALE_W = 28;

  localparam logic [RATE_W-1:0]  WINDOW_RST = 32'd1000000;
  localparam logic [SCALE_W-1:0] RATE_SCALE = 28'd256000000;

  localparam logic REG_WINDOW = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_EV_RD,
    S_EV_CHK,
    S_RATE,
    S_RATE_WAIT,
    S_SUM,
    S_MEAN_WAIT,
    S_DEV,
    S_JIT_WAIT,
    S_DONE
  } swlat_state_t;

endpackage

>>> sv/sliding_window_latency_stats_core.sv
// Sliding window latency statistics: frame count, rate, mean latency and jitter.
//
// Input words carry an emit and a receive timestamp in microseconds; each
// accepted word yields exactly one result word on the output channel.
// in_stall is high from acceptance until the result is loaded into the
// output register, so words are processed one at a time; the next word is
// taken while a finished result still waits on a stalled receiver.
// A zero window skips the rate division. The next word can be accepted in
// the cycle after the result is loaded. The three divisions (rate, mean,
// jitter) run on one shared bit-serial divider and the two passes over the
// held latencies read one memory port, one entry per cycle.
// The window register lies at byte address 0 of the APB port (reset
// 1000000 us); write it only while the block is idle.
// Reset empties the ring and clears the output valid; the sample memories
// are not cleared and only held entries are ever read.
// While out_stall is high the result word holds and the block stalls
// input once its next result is ready.
module sliding_window_latency_stats_core import swlat_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TS_W-1:0]   in_emit_time_us,
  input  logic [TS_W-1:0]   in_receive_time_us,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [FIW_W-1:0]  out_frames_in_window,
  output logic [RATE_W-1:0] out_frame_rate_q8,
  output logic [MEAN_W-1:0] out_mean_latency_q8,
  output logic [MEAN_W-1:0] out_jitter_q8,
  output logic              out_capacity_drop,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SLOT_W = IDX_W + 1;
  localparam int SUM_W  = LAT_W + CNT_W;
  localparam int DVD_W  = MEAN_W + CNT_W;
  localparam int DVS_W  = RATE_W;
  localparam int PROD_W = CNT_W + SCALE_W;

  logic [TS_W-1:0]  arr_mem [DEPTH];
  logic [LAT_W-1:0] lat_mem [DEPTH];
  logic [TS_W-1:0]  arr_q_r;
  logic [LAT_W-1:0] lat_q_r;

  swlat_state_t      state_r, state_nxt;
  logic [RATE_W-1:0] win_r, win_nxt;
  logic [TS_W-1:0]   recv_r, recv_nxt;
  logic [LAT_W-1:0]  lat_r, lat_nxt;
  logic [IDX_W-1:0]  oldest_r, oldest_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              drop_r, drop_nxt;
  logic [IDX_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic              rvld_r, rvld_nxt;
  logic [DVD_W-1:0]  acc_r, acc_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [MEAN_W-1:0] mean_r, mean_nxt;
  logic [MEAN_W-1:0] jit_r, jit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [FIW_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [RATE_W-1:0] out_rate_r, out_rate_nxt;
  logic [MEAN_W-1:0] out_mean_r, out_mean_nxt;
  logic [MEAN_W-1:0] out_jit_r, out_jit_nxt;
  logic              out_drop_r, out_drop_nxt;

  logic [TS_W-1:0]   diff;
  logic [LAT_W-1:0]  lat_in;
  logic              full;
  logic [IDX_W-1:0]  eff_oldest;
  logic [CNT_W-1:0]  eff_count;
  logic [SLOT_W-1:0] slot_sum;
  logic [IDX_W-1:0]  wr_addr;
  logic              mem_we;
  logic              evict;
  logic [PROD_W-1:0] rate_prod;
  logic [MEAN_W-1:0] dev_v;
  logic [MEAN_W-1:0] dev_abs;
  logic              pass_init;
  logic              pass_end;
  logic              cfg_we;
  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic              div_done;
  logic [DVD_W-1:0]  div_quo;

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

  swlat_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    diff = in_receive_time_us - in_emit_time_us;
    if (diff[TS_W-1]) begin
      lat_in = '0;
    end else if (|diff[TS_W-2:LAT_W]) begin
      lat_in = '1;
    end else begin
      lat_in = diff[LAT_W-1:0];
    end

    full       = (count_r == CNT_W'(DEPTH));
    eff_oldest = full ? ring_inc(oldest_r) : oldest_r;
    eff_count  = full ? count_r - 1'b1 : count_r;
    slot_sum   = {1'b0, eff_oldest} + SLOT_W'(eff_count);
    if (slot_sum >= SLOT_W'(DEPTH)) begin
      wr_addr = IDX_W'(slot_sum - SLOT_W'(DEPTH));
    end else begin
      wr_addr = slot_sum[IDX_W-1:0];
    end
    mem_we = (state_r == S_PUSH);

    evict     = (arr_q_r < recv_r) && ((recv_r - arr_q_r) > TS_W'(win_r));
    rate_prod = PROD_W'(count_r) * PROD_W'(RATE_SCALE);
    dev_v     = MEAN_W'(lat_q_r) << Q_FRAC;
    dev_abs   = (dev_v >= mean_r) ? dev_v - mean_r : mean_r - dev_v;
    pass_end  = (iss_r == count_r) && !rvld_r;
    cfg_we    = psel && penable && pwrite && (paddr[2] == REG_WINDOW);

    state_nxt     = state_r;
    win_nxt       = cfg_we ? pwdata : win_r;
    recv_nxt      = recv_r;
    lat_nxt       = lat_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    rd_ptr_nxt    = rd_ptr_r;
    iss_nxt       = iss_r;
    rvld_nxt      = 1'b0;
    acc_nxt       = acc_r;
    rate_nxt      = rate_r;
    mean_nxt      = mean_r;
    jit_nxt       = jit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_cnt_nxt   = out_cnt_r;
    out_rate_nxt  = out_rate_r;
    out_mean_nxt  = out_mean_r;
    out_jit_nxt   = out_jit_r;
    out_drop_nxt  = out_drop_r;
    pass_init     = 1'b0;
    div_start     = 1'b0;
    div_dvd       = DVD_W'(acc_r[SUM_W-1:0]) << Q_FRAC;
    div_dvs       = DVS_W'(count_r);
    in_stall      = (state_r != S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          recv_nxt  = in_receive_time_us;
          lat_nxt   = lat_in;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        oldest_nxt = eff_oldest;
        count_nxt  = eff_count + 1'b1;
        drop_nxt   = full;
        state_nxt  = S_EV_RD;
      end
      S_EV_RD: begin
        state_nxt = S_EV_CHK;
      end
      S_EV_CHK: begin
        if (evict) begin
          oldest_nxt = ring_inc(oldest_r);
          count_nxt  = count_r - 1'b1;
          state_nxt  = S_EV_RD;
        end else begin
          state_nxt = S_RATE;
        end
      end
      S_RATE: begin
        if (win_r == '0) begin
          rate_nxt  = '0;
          pass_init = 1'b1;
          state_nxt = S_SUM;
        end else begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(rate_prod);
          div_dvs   = win_r;
          state_nxt = S_RATE_WAIT;
        end
      end
      S_RATE_WAIT: begin
        if (div_done) begin
          rate_nxt  = (|div_quo[DVD_W-1:RATE_W]) ? '1 : div_quo[RATE_W-1:0];
          pass_init = 1'b1;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (rvld_r) begin
          acc_nxt = acc_r + DVD_W'(lat_q_r);
        end
        if (pass_end) begin
          div_start = 1'b1;
          state_nxt = S_MEAN_WAIT;
        end
      end
      S_MEAN_WAIT: begin
        if (div_done) begin
          mean_nxt  = div_quo[MEAN_W-1:0];
          pass_init = 1'b1;
          state_nxt = S_DEV;
        end
      end
      S_DEV: begin
        if (rvld_r) begin
          acc_nxt = acc_r + DVD_W'(dev_abs);
        end
        if (pass_end) begin
          div_start = 1'b1;
          div_dvd   = acc_r;
          state_nxt = S_JIT_WAIT;
        end
      end
      S_JIT_WAIT: begin
        if (div_done) begin
          jit_nxt   = div_quo[MEAN_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = FIW_W'(count_r);
          out_rate_nxt  = rate_r;
          out_mean_nxt  = mean_r;
          out_jit_nxt   = jit_r;
          out_drop_nxt  = drop_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if ((state_r == S_SUM || state_r == S_DEV) && (iss_r != count_r)) begin
      rd_ptr_nxt = ring_inc(rd_ptr_r);
      iss_nxt    = iss_r + 1'b1;
      rvld_nxt   = 1'b1;
    end
    if (pass_init) begin
      rd_ptr_nxt = oldest_r;
      iss_nxt    = '0;
      acc_nxt    = '0;
      rvld_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      arr_mem[wr_addr] <= recv_r;
      lat_mem[wr_addr] <= lat_r;
    end
    arr_q_r <= arr_mem[oldest_r];
    lat_q_r <= lat_mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= WINDOW_RST;
      oldest_r    <= '0;
      count_r     <= '0;
      iss_r       <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_r       <= win_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      iss_r       <= iss_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    recv_r     <= recv_nxt;
    lat_r      <= lat_nxt;
    drop_r     <= drop_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    acc_r      <= acc_nxt;
    rate_r     <= rate_nxt;
    mean_r     <= mean_nxt;
    jit_r      <= jit_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_rate_r <= out_rate_nxt;
    out_mean_r <= out_mean_nxt;
    out_jit_r  <= out_jit_nxt;
    out_drop_r <= out_drop_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_frames_in_window = out_cnt_r;
  assign out_frame_rate_q8    = out_rate_r;
  assign out_mean_latency_q8  = out_mean_r;
  assign out_jitter_q8        = out_jit_r;
  assign out_capacity_drop    = out_drop_r;
  assign prdata               = (paddr[2] == REG_WINDOW) ? win_r : '0;
  assign pready               = 1'b1;

endmodule

>>> sv/swlat_div.sv
// Restoring divider that produces one quotient bit per cycle.
module swlat_div import swlat_pkg::*; #(
  parameter int DVD_W = 47,
  parameter int DVS_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   trial;
  logic             ge;

  always_comb begin
    shifted  = {rem_r, quo_r[DVD_W-1]};
    trial    = shifted - {1'b0, dvs_r};
    ge       = !trial[DVS_W];
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> tb/swlat_stats_checker.sv
// Checker for the sliding window latency statistics block: predicts each result and compares.
module swlat_stats_checker import swlat_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [TS_W-1:0]   in_emit_time_us,
  input  logic [TS_W-1:0]   in_receive_time_us,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [FIW_W-1:0]  out_frames_in_window,
  input  logic [RATE_W-1:0] out_frame_rate_q8,
  input  logic [MEAN_W-1:0] out_mean_latency_q8,
  input  logic [MEAN_W-1:0] out_jitter_q8,
  input  logic              out_capacity_drop,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  output int                mismatch_count,
  output int                pending_results,
  output int                results_checked,
  output int                drops_flagged,
  output int                rates_saturated
);

  typedef struct packed {
    logic [FIW_W-1:0]  count;
    logic [RATE_W-1:0] rate;
    logic [MEAN_W-1:0] mean;
    logic [MEAN_W-1:0] jitter;
    logic              drop;
  } stats_t;

  logic [TS_W-1:0]  arrival_mem [DEPTH];
  logic [LAT_W-1:0] latency_mem [DEPTH];
  int unsigned      front;
  int unsigned      held;
  logic [31:0]      cfg_window;
  stats_t           stats_due [$];
  int               errs;
  int               checked;
  int               drops;
  int               sats;

  function automatic stats_t predict_window_stats(input logic [TS_W-1:0] emit,
                                                  input logic [TS_W-1:0] recv);
    stats_t           s;
    logic [63:0]      diff;
    logic [LAT_W-1:0] lat;
    logic [63:0]      r;
    logic [63:0]      total;
    logic [63:0]      avg;
    logic [63:0]      spread;
    logic [63:0]      scaled;
    int unsigned      idx;
    s = '0;
    diff = recv - emit;
    if (diff[63]) begin
      lat = '0;
    end else if (diff[63:32] != 0) begin
      lat = '1;
    end else begin
      lat = diff[31:0];
    end
    if (held >= DEPTH) begin
      front = (front + 1) % DEPTH;
      held--;
      s.drop = 1'b1;
    end
    idx = (front + held) % DEPTH;
    arrival_mem[idx] = recv;
    latency_mem[idx] = lat;
    held++;
    while (held > 0 && arrival_mem[front] < recv &&
           recv - arrival_mem[front] > 64'(cfg_window)) begin
      front = (front + 1) % DEPTH;
      held--;
    end
    if (cfg_window != 0) begin
      r = 64'(held) * 64'(RATE_SCALE) / 64'(cfg_window);
      s.rate = (r > 64'hFFFF_FFFF) ? '1 : r[31:0];
    end
    if (held > 0) begin
      total = '0;
      for (int i = 0; i < held; i++) total += 64'(latency_mem[(front + i) % DEPTH]);
      avg = (total << Q_FRAC) / 64'(held);
      spread = '0;
      for (int i = 0; i < held; i++) begin
        scaled = 64'(latency_mem[(front + i) % DEPTH]) << Q_FRAC;
        spread += (scaled >= avg) ? scaled - avg : avg - scaled;
      end
      s.mean = avg[MEAN_W-1:0];
      spread = spread / 64'(held);
      s.jitter = spread[MEAN_W-1:0];
    end
    s.count = FIW_W'(held);
    return s;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    stats_t want;
    if (!rst_n) begin
      front = 0;
      held = 0;
      cfg_window = WINDOW_RST;
      stats_due.delete();
    end else begin
      if (psel && penable && pready && paddr[2] == REG_WINDOW && paddr[1:0] == 2'b00) begin
        if (pwrite) begin
          cfg_window = pwdata;
        end else if (prdata !== cfg_window) begin
          errs++;
          $display("%0t: window readback mismatch, expected %0d, got %0d",
                   $time, cfg_window, prdata);
        end
      end
      if (out_valid && !out_stall) begin
        if (stats_due.size() == 0) begin
          errs++;
          $display("%0t: result word with none expected, expected nothing, got count %0d",
                   $time, out_frames_in_window);
        end else begin
          want = stats_due[0];
          stats_due.delete(0);
          checked++;
          check_field("frames_in_window", 64'(want.count), 64'(out_frames_in_window));
          check_field("frame_rate_q8", 64'(want.rate), 64'(out_frame_rate_q8));
          check_field("mean_latency_q8", 64'(want.mean), 64'(out_mean_latency_q8));
          check_field("jitter_q8", 64'(want.jitter), 64'(out_jitter_q8));
          check_field("capacity_drop", 64'(want.drop), 64'(out_capacity_drop));
        end
      end
      if (in_valid && !in_stall) begin
        want = predict_window_stats(in_emit_time_us, in_receive_time_us);
        if (want.drop) drops++;
        if (cfg_window != 0 && want.rate == '1) sats++;
        stats_due.insert(stats_due.size(), want);
      end
    end
    mismatch_count  <= errs;
    pending_results <= stats_due.size();
    results_checked <= checked;
    drops_flagged   <= drops;
    rates_saturated <= sats;
  end

endmodule

>>> tb/sliding_window_latency_stats_core_tb.sv
// Top of the sliding window latency statistics testbench: clock, reset, stimulus and verdict.
module sliding_window_latency_stats_core_tb;
  import swlat_pkg::*;

  localparam int RING_DEPTH = 64;
  localparam int HOLD_LEN = 3000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;
  localparam logic REG_SPARE = 1'b1;
  localparam logic [2:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};
  localparam logic [2:0] ADDR_SPARE = {REG_SPARE, 2'b00};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [TS_W-1:0]   in_emit_time_us = '0;
  logic [TS_W-1:0]   in_receive_time_us = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [FIW_W-1:0]  out_frames_in_window;
  logic [RATE_W-1:0] out_frame_rate_q8;
  logic [MEAN_W-1:0] out_mean_latency_q8;
  logic [MEAN_W-1:0] out_jitter_q8;
  logic              out_capacity_drop;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic        steady = 1'b0;
  logic        hold_req = 1'b0;
  int          hold_cnt = 0;
  int          quiet_cycles = 0;
  int          frames_sent = 0;
  int          windows_used = 1;
  logic [63:0] now_us = '0;
  logic [31:0] cur_window = WINDOW_RST;

  int mismatch_count;
  int pending_results;
  int results_checked;
  int drops_flagged;
  int rates_saturated;

  always #5 clk = ~clk;

  sliding_window_latency_stats_core #(.DEPTH(RING_DEPTH)) u_dut (.*);

  swlat_stats_checker #(.DEPTH(RING_DEPTH)) u_checker (.*);

  always @(posedge clk) begin
    if (hold_req && hold_cnt < HOLD_LEN) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_stall <= !steady && $urandom_range(99) < 38;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_frame(input logic [63:0] emit, input logic [63:0] recv);
    while (!steady && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_emit_time_us <= emit;
    in_receive_time_us <= recv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames_sent++;
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    int unsigned how;
    logic [63:0] span;
    logic [63:0] step;
    logic [63:0] recv;
    logic [63:0] emit;
    logic [63:0] delay;
    pick = $urandom_range(99);
    span = 64'(cur_window) >> (2 * $urandom_range(0, 4));
    if (pick < 8) begin
      recv = {$urandom, $urandom};
      emit = {$urandom, $urandom};
      if ($urandom_range(1) == 1) now_us = recv;
    end else begin
      if (pick < 18) begin
        recv = now_us;
      end else if (pick < 24) begin
        recv = now_us - ({$urandom, $urandom} % (span + 1));
      end else begin
        if (pick < 28) begin
          step = span * 2 + 64'($urandom_range(1, 1000));
        end else if (span == 0) begin
          step = ($urandom_range(31) == 0) ? 64'd1 : 64'd0;
        end else begin
          step = {$urandom, $urandom} % (span + 1);
        end
        now_us = now_us + step;
        recv = now_us;
      end
      how = $urandom_range(99);
      if (how < 70) begin
        delay = 64'($urandom_range(0, 40000));
      end else if (how < 80) begin
        delay = 64'($urandom);
      end else if (how < 88) begin
        delay = {24'd0, 8'($urandom_range(1, 255)), $urandom};
      end else if (how < 96) begin
        delay = 64'd0 - 64'($urandom_range(1, 100000));
      end else begin
        delay = '0;
      end
      emit = recv - delay;
    end
    send_frame(emit, recv);
  endtask

  task automatic send_random_frames(input int n);
    repeat (n) send_random_frame();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input logic [31:0] win);
    apb_access(1'b1, ADDR_WINDOW, win);
    apb_access(1'b0, ADDR_WINDOW, '0);
    cur_window = win;
    windows_used++;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apb_access(1'b0, ADDR_WINDOW, '0);
    send_frame(64'd0, 64'd0);
    send_frame(64'd0, 64'd1000);
    send_frame(64'd5000, 64'd1500);
    send_frame(64'h1001, 64'h1_0000_1000);
    send_frame(64'h1000, 64'h1_0000_1000);
    send_frame(64'h1_0000_1000, 64'h1_0000_0000);
    send_frame(64'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_frame(64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    now_us = 64'd2000;
    send_random_frames(150);
    drain();

    set_window(32'd0);
    send_frame(64'd100, 64'd5000);
    send_frame(64'd200, 64'd5000);
    send_frame(64'd0, 64'd4999);
    send_frame(64'd0, 64'd5001);
    now_us = 64'd6000;
    send_random_frames(120);
    drain();

    set_window(32'hFFFF_FFFF);
    send_frame(64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFF0);
    send_frame(64'hFFFF_FFFF_FFFF_FF80, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(64'd0, 64'd0);
    now_us = 64'd10;
    send_random_frames(150);
    drain();

    set_window(32'd1);
    send_random_frames(120);
    drain();

    apb_access(1'b1, ADDR_SPARE, $urandom);
    apb_access(1'b0, ADDR_WINDOW, '0);
    set_window($urandom_range(2000, 300000));
    hold_req <= 1'b1;
    send_random_frames(170);
    drain();

    set_window($urandom);
    send_random_frames(170);
    drain();

    steady <= 1'b1;
    set_window(32'd50000);
    send_random_frames(170);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d frames under %0d window settings, incl. zero, all-ones and an unused address.",
             frames_sent, windows_used);
    $display("Checked %0d results: %0d full-ring drops, %0d saturated frame rates.",
             results_checked, drops_flagged, rates_saturated);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
